### hw/rtl/periodic_gradient_noise_octaves_macros.svh
// Assertion helpers shared by the noise block.
`ifndef PERIODIC_GRADIENT_NOISE_OCTAVES_MACROS_SVH
`define PERIODIC_GRADIENT_NOISE_OCTAVES_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PGNO_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PGNO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pgno_pkg.sv
package pgno_pkg;

    // Table geometry and default octave limit.
    localparam int TABLE_DEPTH     = 512;
    localparam int TABLE_AW        = 9;
    localparam int MAX_OCTAVES_DEF = 8;

    // Item actions.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_OCTAVE_COUNT = 3'd0;
    localparam logic [2:0] CFG_LACUNARITY   = 3'd1;
    localparam logic [2:0] CFG_OCTAVE_GAIN  = 3'd2;
    localparam logic [2:0] CFG_BASE_PERIOD  = 3'd3;
    localparam logic [2:0] CFG_RIDGED_MODE  = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [3:0]  RST_OCTAVE_COUNT = 4'd4;
    localparam logic [2:0]  RST_LACUNARITY   = 3'd2;
    localparam logic [15:0] RST_OCTAVE_GAIN  = 16'd32768;
    localparam logic [8:0]  RST_BASE_PERIOD  = 9'd3;
    localparam logic        RST_RIDGED_MODE  = 1'b0;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_MOD,
        S_MODFIX,
        S_SCALE,
        S_F1,
        S_F2,
        S_F3,
        S_RX0,
        S_RX1,
        S_RH00,
        S_RH01,
        S_RH10,
        S_RH11,
        S_H11,
        S_GRAD,
        S_LP1,
        S_LP2,
        S_LP3,
        S_NOISE,
        S_ACC,
        S_R1,
        S_R2,
        S_R3,
        S_NEXT,
        S_DCHK,
        S_DIV,
        S_OUT
    } state_t;

    typedef logic signed [19:0] grad_t;

    // Gradient dot product selected by the low three hash bits.
    function automatic grad_t grad(input logic [2:0] h, input grad_t x, input grad_t y);
        grad_t g;
        case (h)
            3'd0:    g = x + y;
            3'd1:    g = x - y;
            3'd2:    g = y - x;
            3'd3:    g = -x - y;
            3'd4:    g = x;
            3'd5:    g = -x;
            3'd6:    g = y;
            default: g = -y;
        endcase
        return g;
    endfunction

endpackage

### hw/rtl/periodic_gradient_noise_octaves.sv
// Tileable 2D gradient noise summed over octaves, fbm or ridged. A load item
// writes one byte of the 512-entry permutation table and returns nothing. An
// evaluate item returns one Q2.14 result. Its work is a 16-step remainder unit
// for the tile wrap, then for each effective octave the fade multiplies, six
// dependent reads from the table's single read port and the interpolation
// multiplies that follow, with extra ridged steps in ridged mode, and last a
// 15-step divider for the normalization. One item is in work at a time; a
// finished result waits in the output register while the next item is taken.
module periodic_gradient_noise_octaves #(
    parameter int MAX_OCTAVES = pgno_pkg::MAX_OCTAVES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                action,
    input  logic [8:0]          table_index,
    input  logic [7:0]          table_value,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    output logic                result_valid,
    input  logic                result_stall,
    output logic signed [15:0]  noise_value,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
    localparam int FREQ_W = 2 * MAX_OCTAVES - 1;
    localparam int PER_W  = FREQ_W + 9;
    localparam int SCL_W  = FREQ_W + 25;
    localparam int NORM_W = 17 + OCT_W;
    localparam int SUM_W  = 35 + OCT_W;

    // Configuration registers.
    logic [3:0]  octave_count_reg;
    logic [2:0]  lacunarity_reg;
    logic [15:0] octave_gain_reg;
    logic [8:0]  base_period_reg;
    logic        ridged_mode_reg;

    pgno_pkg::state_t state_reg, state_next;

    // Datapath registers.
    logic [15:0] fracx_reg, fracy_reg, magx_reg, magy_reg;
    logic        negx_reg, negy_reg;
    logic [8:0]  remx_reg, remy_reg;
    logic [3:0]  bit_cnt_reg;
    logic [24:0] xr_reg, yr_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [PER_W-1:0]  period_reg, cellx_reg, celly_reg;
    logic [16:0] amp_reg, weight_reg;
    logic [NORM_W-1:0] norm_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [OCT_W-1:0] oct_reg;
    logic [15:0] fx_reg, fy_reg, px_reg, py_reg, qx_reg, qy_reg;
    logic [20:0] rx_reg, ry_reg;
    logic [16:0] ux_reg, uy_reg;
    logic [7:0]  x0_reg, x1_reg, y0_reg, y1_reg, px0_reg, px1_reg;
    logic [2:0]  h00_reg, h01_reg, h10_reg, h11_reg;
    pgno_pkg::grad_t g00_reg, g01_reg, g10_reg, g11_reg;
    logic signed [38:0] plo_reg, phi_reg, pn_reg;
    logic signed [19:0] lo_reg, hi_reg, n_reg, t_reg;
    logic [SUM_W-1:0] mag_reg, dsh_reg;
    logic [14:0] quo_reg;
    logic        sneg_reg, sat_reg;
    logic [15:0] noise_value_reg;
    logic        result_valid_reg;
    logic [7:0]  perm_rd_reg;

    // Permutation table.
    logic [7:0] perm_mem [pgno_pkg::TABLE_DEPTH];

    logic [pgno_pkg::TABLE_AW-1:0] mem_raddr;
    logic mem_we, eval_acc, out_load;

    // Effective configuration after clamping.
    logic [OCT_W-1:0] oc_eff;
    logic [2:0] lac_eff;
    logic [8:0] base_eff;

    always_comb
    begin
        if (octave_count_reg == 4'd0)
            oc_eff = OCT_W'(1);
        else if (int'(octave_count_reg) > MAX_OCTAVES)
            oc_eff = OCT_W'(MAX_OCTAVES);
        else
            oc_eff = OCT_W'(octave_count_reg);
        if (lacunarity_reg == 3'd0)
            lac_eff = 3'd1;
        else if (lacunarity_reg > 3'd4)
            lac_eff = 3'd4;
        else
            lac_eff = lacunarity_reg;
        base_eff = (base_period_reg == 9'd0) ? 9'd1 : base_period_reg;
    end

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= pgno_pkg::RST_OCTAVE_COUNT;
            lacunarity_reg   <= pgno_pkg::RST_LACUNARITY;
            octave_gain_reg  <= pgno_pkg::RST_OCTAVE_GAIN;
            base_period_reg  <= pgno_pkg::RST_BASE_PERIOD;
            ridged_mode_reg  <= pgno_pkg::RST_RIDGED_MODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pgno_pkg::CFG_OCTAVE_COUNT: octave_count_reg <= cfg_data[3:0];
                pgno_pkg::CFG_LACUNARITY:   lacunarity_reg   <= cfg_data[2:0];
                pgno_pkg::CFG_OCTAVE_GAIN:  octave_gain_reg  <= cfg_data;
                pgno_pkg::CFG_BASE_PERIOD:  base_period_reg  <= cfg_data[8:0];
                pgno_pkg::CFG_RIDGED_MODE:  ridged_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input handshake.
    assign item_stall = (state_reg != pgno_pkg::S_IDLE);
    assign mem_we     = item_valid && !item_stall && (action == pgno_pkg::ACT_LOAD);
    assign eval_acc   = item_valid && !item_stall && (action == pgno_pkg::ACT_EVAL);

    // Table memory: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            perm_mem[table_index] <= table_value;
        perm_rd_reg <= perm_mem[mem_raddr];
    end

    // Remainder step for the tile wrap of the integer coordinate.
    logic [9:0] shx, shy;
    logic [8:0] remx_step, remy_step;
    assign shx = {remx_reg, magx_reg[15]};
    assign shy = {remy_reg, magy_reg[15]};
    assign remx_step = (shx >= {1'b0, base_eff}) ? 9'(shx - {1'b0, base_eff}) : shx[8:0];
    assign remy_step = (shy >= {1'b0, base_eff}) ? 9'(shy - {1'b0, base_eff}) : shy[8:0];

    // Scaled coordinate inside one tile.
    logic [SCL_W-1:0] sclx, scly;
    logic [PER_W:0] cellx_inc, celly_inc;
    assign sclx = SCL_W'(xr_reg) * SCL_W'(freq_reg);
    assign scly = SCL_W'(yr_reg) * SCL_W'(freq_reg);
    assign cellx_inc = {1'b0, cellx_reg} + (PER_W + 1)'(1);
    assign celly_inc = {1'b0, celly_reg} + (PER_W + 1)'(1);

    // Fade curve terms.
    logic [31:0] sqx, sqy, cubx, cuby;
    logic [21:0] rpolx, rpoly;
    logic [36:0] fadex, fadey;
    assign sqx   = 32'(fx_reg) * 32'(fx_reg);
    assign sqy   = 32'(fy_reg) * 32'(fy_reg);
    assign cubx  = 32'(px_reg) * 32'(fx_reg);
    assign cuby  = 32'(py_reg) * 32'(fy_reg);
    assign rpolx = 22'd655360 + 22'(px_reg) * 22'd6 - 22'(fx_reg) * 22'd15;
    assign rpoly = 22'd655360 + 22'(py_reg) * 22'd6 - 22'(fy_reg) * 22'd15;
    assign fadex = 37'(qx_reg) * 37'(rx_reg);
    assign fadey = 37'(qy_reg) * 37'(ry_reg);

    // Corner offsets for the gradients.
    pgno_pkg::grad_t gx0, gx1, gy0, gy1;
    assign gx0 = $signed({4'b0, fx_reg});
    assign gy0 = $signed({4'b0, fy_reg});
    assign gx1 = gx0 - 20'sd65536;
    assign gy1 = gy0 - 20'sd65536;

    // Interpolation products.
    logic signed [38:0] lp_lo, lp_hi, lp_n;
    assign lp_lo = $signed({1'b0, ux_reg}) * (21'(g10_reg) - 21'(g00_reg));
    assign lp_hi = $signed({1'b0, ux_reg}) * (21'(g11_reg) - 21'(g01_reg));
    assign lp_n  = $signed({1'b0, uy_reg}) * (21'(hi_reg) - 21'(lo_reg));

    // Octave accumulation.
    logic signed [19:0] n_abs;
    logic signed [39:0] tsq;
    logic signed [37:0] tw, acc_term;
    logic [32:0] amp_prod;
    assign n_abs    = n_reg[19] ? -n_reg : n_reg;
    assign tsq      = t_reg * t_reg;
    assign tw       = t_reg * $signed({1'b0, weight_reg});
    assign acc_term = ((state_reg == pgno_pkg::S_R3) ? t_reg : n_reg)
                      * $signed({1'b0, amp_reg});
    assign amp_prod = 33'(amp_reg) * 33'(octave_gain_reg);

    // Normalization divider terms.
    logic [SUM_W-1:0] sum_abs, norm_ext;
    assign sum_abs  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign norm_ext = SUM_W'(norm_reg);

    // Saturated, signed result.
    logic [15:0] res_val;
    always_comb
    begin
        if (sat_reg)
            res_val = sneg_reg ? 16'h8000 : 16'h7FFF;
        else if (sneg_reg)
            res_val = 16'(16'd0 - {1'b0, quo_reg});
        else
            res_val = {1'b0, quo_reg};
    end

    // Sequencer: next state, table address and output load.
    always_comb
    begin
        state_next = state_reg;
        mem_raddr  = '0;
        out_load   = 1'b0;
        case (state_reg)
            pgno_pkg::S_IDLE:
            begin
                if (eval_acc)
                    state_next = pgno_pkg::S_MOD;
            end
            pgno_pkg::S_MOD:
            begin
                if (bit_cnt_reg == 4'd0)
                    state_next = pgno_pkg::S_MODFIX;
            end
            pgno_pkg::S_MODFIX: state_next = pgno_pkg::S_SCALE;
            pgno_pkg::S_SCALE:  state_next = pgno_pkg::S_F1;
            pgno_pkg::S_F1:     state_next = pgno_pkg::S_F2;
            pgno_pkg::S_F2:     state_next = pgno_pkg::S_F3;
            pgno_pkg::S_F3:     state_next = pgno_pkg::S_RX0;
            pgno_pkg::S_RX0:
            begin
                mem_raddr  = {1'b0, x0_reg};
                state_next = pgno_pkg::S_RX1;
            end
            pgno_pkg::S_RX1:
            begin
                mem_raddr  = {1'b0, x1_reg};
                state_next = pgno_pkg::S_RH00;
            end
            pgno_pkg::S_RH00:
            begin
                mem_raddr  = 9'(px0_reg) + 9'(y0_reg);
                state_next = pgno_pkg::S_RH01;
            end
            pgno_pkg::S_RH01:
            begin
                mem_raddr  = 9'(px0_reg) + 9'(y1_reg);
                state_next = pgno_pkg::S_RH10;
            end
            pgno_pkg::S_RH10:
            begin
                mem_raddr  = 9'(px1_reg) + 9'(y0_reg);
                state_next = pgno_pkg::S_RH11;
            end
            pgno_pkg::S_RH11:
            begin
                mem_raddr  = 9'(px1_reg) + 9'(y1_reg);
                state_next = pgno_pkg::S_H11;
            end
            pgno_pkg::S_H11:   state_next = pgno_pkg::S_GRAD;
            pgno_pkg::S_GRAD:  state_next = pgno_pkg::S_LP1;
            pgno_pkg::S_LP1:   state_next = pgno_pkg::S_LP2;
            pgno_pkg::S_LP2:   state_next = pgno_pkg::S_LP3;
            pgno_pkg::S_LP3:   state_next = pgno_pkg::S_NOISE;
            pgno_pkg::S_NOISE: state_next = pgno_pkg::S_ACC;
            pgno_pkg::S_ACC:
            begin
                state_next = ridged_mode_reg ? pgno_pkg::S_R1 : pgno_pkg::S_NEXT;
            end
            pgno_pkg::S_R1: state_next = pgno_pkg::S_R2;
            pgno_pkg::S_R2: state_next = pgno_pkg::S_R3;
            pgno_pkg::S_R3: state_next = pgno_pkg::S_NEXT;
            pgno_pkg::S_NEXT:
            begin
                if (oct_reg == oc_eff - OCT_W'(1))
                    state_next = pgno_pkg::S_DCHK;
                else
                    state_next = pgno_pkg::S_SCALE;
            end
            pgno_pkg::S_DCHK: state_next = pgno_pkg::S_DIV;
            pgno_pkg::S_DIV:
            begin
                if (bit_cnt_reg == 4'd0)
                    state_next = pgno_pkg::S_OUT;
            end
            pgno_pkg::S_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = pgno_pkg::S_IDLE;
                end
            end
            default: state_next = pgno_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pgno_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers, stepped by the sequencer.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            pgno_pkg::S_IDLE:
            begin
                fracx_reg   <= coord_x[15:0];
                fracy_reg   <= coord_y[15:0];
                negx_reg    <= coord_x[31];
                negy_reg    <= coord_y[31];
                magx_reg    <= coord_x[31] ? 16'(16'd0 - coord_x[31:16]) : coord_x[31:16];
                magy_reg    <= coord_y[31] ? 16'(16'd0 - coord_y[31:16]) : coord_y[31:16];
                remx_reg    <= '0;
                remy_reg    <= '0;
                bit_cnt_reg <= 4'd15;
            end
            pgno_pkg::S_MOD:
            begin
                remx_reg    <= remx_step;
                remy_reg    <= remy_step;
                magx_reg    <= {magx_reg[14:0], 1'b0};
                magy_reg    <= {magy_reg[14:0], 1'b0};
                bit_cnt_reg <= bit_cnt_reg - 4'd1;
            end
            pgno_pkg::S_MODFIX:
            begin
                xr_reg     <= {(negx_reg && remx_reg != 9'd0) ? 9'(base_eff - remx_reg)
                                                               : remx_reg, fracx_reg};
                yr_reg     <= {(negy_reg && remy_reg != 9'd0) ? 9'(base_eff - remy_reg)
                                                               : remy_reg, fracy_reg};
                freq_reg   <= FREQ_W'(1);
                period_reg <= PER_W'(base_eff);
                amp_reg    <= ridged_mode_reg ? 17'd32768 : 17'd65536;
                weight_reg <= 17'd65536;
                norm_reg   <= '0;
                sum_reg    <= '0;
                oct_reg    <= '0;
            end
            pgno_pkg::S_SCALE:
            begin
                cellx_reg <= sclx[SCL_W-1:16];
                celly_reg <= scly[SCL_W-1:16];
                fx_reg    <= sclx[15:0];
                fy_reg    <= scly[15:0];
            end
            pgno_pkg::S_F1:
            begin
                x0_reg <= cellx_reg[7:0];
                y0_reg <= celly_reg[7:0];
                x1_reg <= (cellx_inc == {1'b0, period_reg}) ? 8'd0 : cellx_inc[7:0];
                y1_reg <= (celly_inc == {1'b0, period_reg}) ? 8'd0 : celly_inc[7:0];
                px_reg <= sqx[31:16];
                py_reg <= sqy[31:16];
            end
            pgno_pkg::S_F2:
            begin
                qx_reg <= cubx[31:16];
                qy_reg <= cuby[31:16];
                rx_reg <= rpolx[20:0];
                ry_reg <= rpoly[20:0];
            end
            pgno_pkg::S_F3:
            begin
                ux_reg <= fadex[32:16];
                uy_reg <= fadey[32:16];
            end
            pgno_pkg::S_RX1:  px0_reg <= perm_rd_reg;
            pgno_pkg::S_RH00: px1_reg <= perm_rd_reg;
            pgno_pkg::S_RH01: h00_reg <= perm_rd_reg[2:0];
            pgno_pkg::S_RH10: h01_reg <= perm_rd_reg[2:0];
            pgno_pkg::S_RH11: h10_reg <= perm_rd_reg[2:0];
            pgno_pkg::S_H11:  h11_reg <= perm_rd_reg[2:0];
            pgno_pkg::S_GRAD:
            begin
                g00_reg <= pgno_pkg::grad(h00_reg, gx0, gy0);
                g10_reg <= pgno_pkg::grad(h10_reg, gx1, gy0);
                g01_reg <= pgno_pkg::grad(h01_reg, gx0, gy1);
                g11_reg <= pgno_pkg::grad(h11_reg, gx1, gy1);
            end
            pgno_pkg::S_LP1:
            begin
                plo_reg <= lp_lo;
                phi_reg <= lp_hi;
            end
            pgno_pkg::S_LP2:
            begin
                lo_reg <= g00_reg + 20'(plo_reg >>> 16);
                hi_reg <= g01_reg + 20'(phi_reg >>> 16);
            end
            pgno_pkg::S_LP3:   pn_reg <= lp_n;
            pgno_pkg::S_NOISE: n_reg  <= lo_reg + 20'(pn_reg >>> 16);
            pgno_pkg::S_ACC:
            begin
                t_reg <= 20'sd65536 - n_abs;
                if (!ridged_mode_reg)
                    sum_reg <= sum_reg + SUM_W'(acc_term);
            end
            pgno_pkg::S_R1: t_reg <= 20'(tsq >>> 16);
            pgno_pkg::S_R2: t_reg <= 20'(tw >>> 16);
            pgno_pkg::S_R3:
            begin
                weight_reg <= (t_reg > 20'sd32768) ? 17'd65536 : {t_reg[15:0], 1'b0};
                sum_reg    <= sum_reg + SUM_W'(acc_term);
            end
            pgno_pkg::S_NEXT:
            begin
                norm_reg   <= norm_reg + NORM_W'(amp_reg);
                amp_reg    <= amp_prod[32:16];
                freq_reg   <= FREQ_W'(freq_reg * FREQ_W'(lac_eff));
                period_reg <= PER_W'(period_reg * PER_W'(lac_eff));
                oct_reg    <= oct_reg + OCT_W'(1);
            end
            pgno_pkg::S_DCHK:
            begin
                mag_reg     <= sum_abs;
                dsh_reg     <= norm_ext << 16;
                sat_reg     <= (sum_abs >= (norm_ext << 17));
                sneg_reg    <= sum_reg[SUM_W-1];
                quo_reg     <= '0;
                bit_cnt_reg <= 4'd14;
            end
            pgno_pkg::S_DIV:
            begin
                if (mag_reg >= dsh_reg)
                    mag_reg <= mag_reg - dsh_reg;
                quo_reg     <= {quo_reg[13:0], (mag_reg >= dsh_reg)};
                dsh_reg     <= dsh_reg >> 1;
                bit_cnt_reg <= bit_cnt_reg - 4'd1;
            end
            default: ;
        endcase
    end

    // Output register, free to hold a result while the next item runs.
    always_ff @(posedge clk)
    begin
        if (out_load)
            noise_value_reg <= res_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (out_load)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    assign result_valid = result_valid_reg;
    assign noise_value  = $signed(noise_value_reg);

`include "periodic_gradient_noise_octaves_macros.svh"

    // An evaluate item starts the tile wrap on the next cycle.
    `PGNO_ASSERT_NEXT(a_eval_start, eval_acc, state_reg == pgno_pkg::S_MOD, "evaluate did not start")
    // A load item leaves the sequencer idle.
    `PGNO_ASSERT_NEXT(a_load_idle, mem_we, state_reg == pgno_pkg::S_IDLE, "load left idle")
    // The wrap remainder stays below the base period.
    `PGNO_ASSERT_SAME(a_rem_bound, state_reg == pgno_pkg::S_MOD, remx_reg < base_eff && remy_reg < base_eff, "remainder out of range")
    // The octave index never passes the configured count.
    `PGNO_ASSERT_SAME(a_oct_bound, state_reg == pgno_pkg::S_NEXT, oct_reg < oc_eff, "octave index overrun")
    // A loaded result is presented on the next cycle.
    `PGNO_ASSERT_NEXT(a_out_shown, out_load, result_valid_reg, "result not presented")

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes past the end of the list; writes to them are ignored.
    localparam logic [2:0] CFG_SPARE_LO = 3'd5;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    localparam int         DRAIN_CYCLES = 260;
    localparam longint     CYCLE_LIMIT  = 3000000;
    localparam longint     ONE_Q16      = 65536;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    logic               action = pgno_pkg::ACT_LOAD;
    logic [8:0]         table_index = '0;
    logic [7:0]         table_value = '0;
    logic signed [31:0] coord_x = '0;
    logic signed [31:0] coord_y = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [15:0] noise_value;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    // Shadow copy of the permutation table and the registers.
    logic [7:0]  perm_shadow [pgno_pkg::TABLE_DEPTH];
    logic [3:0]  octaves_reg;
    logic [2:0]  lacunarity_reg;
    logic [15:0] gain_reg;
    logic [8:0]  period_reg;
    logic        ridged_reg;

    logic signed [15:0] pending_noise [$];
    int     error_count = 0;
    bit     send_gaps = 1'b0;
    bit     stall_gaps = 1'b0;
    int     long_hold = 0;
    longint cycle_count = 0;

    periodic_gradient_noise_octaves dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .table_index  (table_index),
        .table_value  (table_value),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .noise_value  (noise_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Run-length guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result receiver: long hold-offs on request, otherwise short random bursts.
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold > 0)
            begin
                result_stall <= 1'b1;
                long_hold = long_hold - 1;
            end
            else if (burst > 0)
            begin
                result_stall <= 1'b1;
                burst = burst - 1;
            end
            else if (stall_gaps && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                burst = $urandom_range(0, 3);
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Each accepted result is checked against the oldest expected value.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_noise.size() == 0)
            begin
                $error("noise_value: unexpected result %0d", noise_value);
                error_count++;
            end
            else
            begin
                if (noise_value !== pending_noise[0])
                begin
                    $error("noise_value: expected %0d, actual %0d",
                           pending_noise[0], noise_value);
                    error_count++;
                end
                void'(pending_noise.pop_front());
            end
        end
    end

    // Quintic fade curve on a Q0.16 fraction.
    function automatic longint fade_curve(longint f);
        longint p, q, r;
        p = (f * f) >>> 16;
        q = (p * f) >>> 16;
        r = 6 * p - 15 * f + 10 * ONE_Q16;
        return (q * r) >>> 16;
    endfunction

    function automatic longint blend(longint a, longint b, longint t);
        return a + ((t * (b - a)) >>> 16);
    endfunction

    function automatic longint gradient_dot(logic [7:0] h, longint x, longint y);
        case (h[2:0])
            3'd0:    return x + y;
            3'd1:    return x - y;
            3'd2:    return y - x;
            3'd3:    return -x - y;
            3'd4:    return x;
            3'd5:    return -x;
            3'd6:    return y;
            default: return -y;
        endcase
    endfunction

    function automatic int tile_cell(longint c, longint period);
        longint r;
        r = c % period;
        if (r < 0)
            r += period;
        return int'(r & 255);
    endfunction

    // Gradient noise of one octave at a scaled Q16.16 point.
    function automatic longint lattice_noise(longint sx, longint sy, longint period);
        longint cx, cy, fx, fy, u, v, lo, hi;
        int x0, x1, y0, y1;
        logic [7:0] px0, px1, h00, h01, h10, h11;
        cx = sx >>> 16;
        cy = sy >>> 16;
        fx = sx & 64'hFFFF;
        fy = sy & 64'hFFFF;
        x0 = tile_cell(cx, period);
        x1 = tile_cell(cx + 1, period);
        y0 = tile_cell(cy, period);
        y1 = tile_cell(cy + 1, period);
        u = fade_curve(fx);
        v = fade_curve(fy);
        px0 = perm_shadow[x0];
        px1 = perm_shadow[x1];
        h00 = perm_shadow[(px0 + y0) % pgno_pkg::TABLE_DEPTH];
        h01 = perm_shadow[(px0 + y1) % pgno_pkg::TABLE_DEPTH];
        h10 = perm_shadow[(px1 + y0) % pgno_pkg::TABLE_DEPTH];
        h11 = perm_shadow[(px1 + y1) % pgno_pkg::TABLE_DEPTH];
        lo = blend(gradient_dot(h00, fx, fy), gradient_dot(h10, fx - ONE_Q16, fy), u);
        hi = blend(gradient_dot(h01, fx, fy - ONE_Q16),
                   gradient_dot(h11, fx - ONE_Q16, fy - ONE_Q16), u);
        return blend(lo, hi, v);
    endfunction

    // Normalized octave sum at a point under the current register settings.
    function automatic logic signed [15:0] octave_sum(logic signed [31:0] px,
                                                       logic signed [31:0] py);
        longint oct, lac, period, freq, amp, norm, total, weight, n, v, res, x, y;
        oct = (octaves_reg == 0) ? 1 : (octaves_reg > 8 ? 8 : longint'(octaves_reg));
        lac = (lacunarity_reg == 0) ? 1 : (lacunarity_reg > 4 ? 4 : longint'(lacunarity_reg));
        period = (period_reg == 0) ? 1 : longint'(period_reg);
        x = px;
        y = py;
        freq = 1;
        amp = ridged_reg ? ONE_Q16 / 2 : ONE_Q16;
        norm = 0;
        total = 0;
        weight = ONE_Q16;
        for (longint k = 0; k < oct; k++)
        begin
            n = lattice_noise(x * freq, y * freq, period);
            if (ridged_reg)
            begin
                v = ONE_Q16 - (n < 0 ? -n : n);
                v = (v * v) >>> 16;
                v = (v * weight) >>> 16;
                weight = (2 * v > ONE_Q16) ? ONE_Q16 : 2 * v;
                total += v * amp;
            end
            else
                total += n * amp;
            norm += amp;
            amp = (amp * longint'(gain_reg)) >>> 16;
            freq *= lac;
            period *= lac;
        end
        res = total / (norm * 4);
        if (res > 32767)
            res = 32767;
        if (res < -32768)
            res = -32768;
        return res[15:0];
    endfunction

    // Sends one item and records its table write or expected result; a random gap may follow.
    task automatic send_item(logic act, logic [8:0] idx, logic [7:0] val,
                             logic signed [31:0] x, logic signed [31:0] y);
        item_valid  <= 1'b1;
        action      <= act;
        table_index <= idx;
        table_value <= val;
        coord_x     <= x;
        coord_y     <= y;
        do
            @(posedge clk);
        while (item_stall);
        if (act == pgno_pkg::ACT_LOAD)
            perm_shadow[idx] = val;
        else
            pending_noise.push_back(octave_sum(x, y));
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic evaluate(logic signed [31:0] x, logic signed [31:0] y);
        send_item(pgno_pkg::ACT_EVAL, 9'($urandom_range(0, 511)),
                  8'($urandom_range(0, 255)), x, y);
    endtask

    // Stops sending and waits until every expected result has come and the
    // block has had time to finish any load.
    task automatic drain();
        item_valid <= 1'b0;
        while (pending_noise.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pgno_pkg::CFG_OCTAVE_COUNT: octaves_reg    = val[3:0];
            pgno_pkg::CFG_LACUNARITY:   lacunarity_reg = val[2:0];
            pgno_pkg::CFG_OCTAVE_GAIN:  gain_reg       = val;
            pgno_pkg::CFG_BASE_PERIOD:  period_reg     = val[8:0];
            pgno_pkg::CFG_RIDGED_MODE:  ridged_reg     = val[0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [3:0] oct, logic [2:0] lac, logic [15:0] gain,
                           logic [8:0] period, logic ridged);
        write_reg(pgno_pkg::CFG_OCTAVE_COUNT, 16'(oct));
        write_reg(pgno_pkg::CFG_LACUNARITY, 16'(lac));
        write_reg(pgno_pkg::CFG_OCTAVE_GAIN, gain);
        write_reg(pgno_pkg::CFG_BASE_PERIOD, 16'(period));
        write_reg(pgno_pkg::CFG_RIDGED_MODE, 16'(ridged));
    endtask

    // Every entry must be written before any evaluate reads it.
    task automatic test_table_fill();
        for (int i = 0; i < pgno_pkg::TABLE_DEPTH; i++)
            send_item(pgno_pkg::ACT_LOAD, i[8:0], (i == 0) ? 8'd0 : (i == 511 ? 8'd255
                      : 8'($urandom_range(0, 255))), $urandom, $urandom);
        drain();
    endtask

    // Coordinate extremes under the reset settings.
    task automatic test_reset_settings();
        evaluate(32'sh0, 32'sh0);
        evaluate(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        evaluate(32'sh80000000, 32'sh80000000);
        evaluate(-32'sd1, 32'sh0000FFFF);
        evaluate(32'sh00030000, -32'sh00010000);
        evaluate(32'sh00018000, 32'sh7FFF8000);
        drain();
    endtask

    // Register extremes and the clamped encodings.
    task automatic test_register_extremes();
        set_all(4'd1, 3'd1, 16'd0, 9'd1, 1'b0);
        evaluate(32'sh12345678, -32'sh0ABCDEF0);
        evaluate(32'sh7FFFFFFF, 32'sh80000000);
        drain();
        set_all(4'd8, 3'd4, 16'hFFFF, 9'd256, 1'b1);
        evaluate(32'sh7FFFFFFF, 32'sh80000000);
        evaluate(32'sh00008000, 32'sh00008000);
        drain();
        set_all(4'd0, 3'd0, 16'd32768, 9'd0, 1'b1);
        evaluate(32'sh00054321, 32'sh00123456);
        drain();
        set_all(4'd15, 3'd7, 16'hC000, 9'd511, 1'b0);
        evaluate(-32'sh00054321, 32'sh7FFF0000);
        evaluate(32'sh0, -32'sd1);
        drain();
        // Writes beyond the register list must change nothing.
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0000);
        evaluate(32'sh00020000, 32'sh00020000);
        drain();
    endtask

    // The receiver holds off long enough that the block backs up its input.
    task automatic test_backpressure();
        set_all(4'd2, 3'd2, 16'd40000, 9'd5, 1'b0);
        long_hold = 600;
        for (int i = 0; i < 8; i++)
            evaluate($urandom, $urandom);
        drain();
    endtask

    // Random settings per phase, random loads and evaluates within a phase.
    task automatic test_random_phase(int count, bit gaps);
        logic [3:0] oct;
        send_gaps  = gaps;
        stall_gaps = gaps;
        oct = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, 3));
        set_all(oct, 3'($urandom_range(0, 7)), 16'($urandom),
                9'($urandom_range(0, 511)), 1'($urandom));
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                send_item(pgno_pkg::ACT_LOAD, 9'($urandom), 8'($urandom),
                          $urandom, $urandom);
            else if ($urandom_range(0, 3) == 0)
                evaluate($urandom_range(0, 32'h000FFFFF) - 32'h00080000,
                         $urandom_range(0, 32'h000FFFFF) - 32'h00080000);
            else
                evaluate($urandom, $urandom);
        end
        drain();
    endtask

    initial
    begin
        octaves_reg    = pgno_pkg::RST_OCTAVE_COUNT;
        lacunarity_reg = pgno_pkg::RST_LACUNARITY;
        gain_reg       = pgno_pkg::RST_OCTAVE_GAIN;
        period_reg     = pgno_pkg::RST_BASE_PERIOD;
        ridged_reg     = pgno_pkg::RST_RIDGED_MODE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_fill();
        test_reset_settings();
        test_register_extremes();
        send_gaps  = 1'b1;
        stall_gaps = 1'b1;
        test_backpressure();
        for (int p = 0; p < 8; p++)
            test_random_phase(170, 1'b1);
        test_random_phase(150, 1'b0);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
